// ----- sv/ssrl_pkg.sv -----
// ----------------------------------------------------------------------------
// Setpoint smoother package
// Shared payload types, status group and constants of the setpoint smoother.
// ----------------------------------------------------------------------------
package ssrl_pkg;

  localparam int unsigned HIST_DEPTH = 5;
  localparam int unsigned VAL_W = 8;
  localparam int unsigned SUM_W = 15;
  localparam int unsigned AVG_SHIFT = 7;
  localparam logic [VAL_W-1:0] VAL_MAX = 8'd255;
  localparam logic [VAL_W-1:0] STEP_RESET = 8'd50;
  localparam int unsigned WEIGHT_SHIFT [HIST_DEPTH] = '{6, 5, 4, 3, 3};

  typedef struct packed {
    logic               has_value;
    logic               parse_ok;
    logic signed [15:0] entered_value;
    logic signed [7:0]  encoder_delta;
    logic [7:0]         current_speed;
  } in_t;

  typedef struct packed {
    logic [7:0] new_speed;
    logic [7:0] target_average;
    logic       conversion_failed;
    logic       missing_input;
    logic       encoder_used;
    logic       clamped_high;
    logic       clamped_low;
  } out_t;

  typedef struct packed {
    logic conversion_failed;
    logic encoder_used;
    logic clamped_high;
    logic clamped_low;
  } status_t;

endpackage

// ----- sv/ssrl_head.sv -----
// ----------------------------------------------------------------------------
// Setpoint smoother head
// Forms the newest history entry from the input and keeps the sticky flags.
// ----------------------------------------------------------------------------
module ssrl_head (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  ssrl_pkg::in_t             item,
  input  logic [ssrl_pkg::VAL_W-1:0] newest_old,
  output logic [ssrl_pkg::VAL_W-1:0] newest,
  output ssrl_pkg::status_t         status
);

  logic                       high_flag;
  logic                       low_flag;
  logic                       high_flag_next;
  logic                       low_flag_next;
  logic                       take;
  logic [ssrl_pkg::VAL_W-1:0] entered_clamped;
  logic [ssrl_pkg::VAL_W-1:0] base;
  logic signed [9:0]          adjusted;

  assign take = item.has_value && item.parse_ok;

  always_comb begin
    if (item.entered_value < 0) begin
      entered_clamped = '0;
    end else if (item.entered_value > 16'sd255) begin
      entered_clamped = ssrl_pkg::VAL_MAX;
    end else begin
      entered_clamped = item.entered_value[7:0];
    end
  end

  assign base = take ? entered_clamped : newest_old;
  assign adjusted = $signed({2'b00, base}) + 10'(item.encoder_delta);

  always_comb begin
    if (item.encoder_delta == '0) begin
      newest = base;
    end else if (adjusted < 0) begin
      newest = '0;
    end else if (adjusted > 10'sd255) begin
      newest = ssrl_pkg::VAL_MAX;
    end else begin
      newest = adjusted[7:0];
    end
  end

  assign high_flag_next = take ? (item.entered_value > 16'sd255) : high_flag;
  assign low_flag_next = take ? (item.entered_value < 0) : low_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_flag <= 1'b0;
      low_flag <= 1'b0;
    end else if (advance) begin
      high_flag <= high_flag_next;
      low_flag <= low_flag_next;
    end
  end

  assign status.conversion_failed = item.has_value && !item.parse_ok;
  assign status.encoder_used = item.encoder_delta != '0;
  assign status.clamped_high = high_flag_next;
  assign status.clamped_low = low_flag_next;

endmodule

// ----- sv/ssrl_cell.sv -----
// ----------------------------------------------------------------------------
// Setpoint history cell
// Holds one history entry, takes its neighbor's entry on each transfer and
// adds its weighted share to the running sum passed along the chain.
// ----------------------------------------------------------------------------
module ssrl_cell #(
  parameter int unsigned SHIFT = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [ssrl_pkg::VAL_W-1:0] value_in,
  input  logic [ssrl_pkg::SUM_W-1:0] sum_in,
  output logic [ssrl_pkg::VAL_W-1:0] value,
  output logic [ssrl_pkg::SUM_W-1:0] sum_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (advance) begin
      value <= value_in;
    end
  end

  assign sum_out = sum_in + (ssrl_pkg::SUM_W'(value_in) << SHIFT);

endmodule

// ----- sv/ssrl_ramp.sv -----
// ----------------------------------------------------------------------------
// Ramp limiter
// Moves the present speed toward the target by at most the step limit.
// ----------------------------------------------------------------------------
module ssrl_ramp (
  input  logic [ssrl_pkg::VAL_W-1:0] target,
  input  logic [ssrl_pkg::VAL_W-1:0] current_speed,
  input  logic [ssrl_pkg::VAL_W-1:0] max_step,
  output logic [ssrl_pkg::VAL_W-1:0] new_speed
);

  logic signed [9:0] diff;
  logic signed [9:0] step;

  assign diff = $signed({2'b00, target}) - $signed({2'b00, current_speed});
  assign step = $signed({2'b00, max_step});

  always_comb begin
    if (diff <= step && diff >= -step) begin
      new_speed = target;
    end else if (diff > 0) begin
      new_speed = current_speed + max_step;
    end else begin
      new_speed = current_speed - max_step;
    end
  end

endmodule

// ----- sv/setpoint_smoother_ramp_limiter_top.sv -----
// ----------------------------------------------------------------------------
// Setpoint smoother with ramp limiter
// Each input transfer is one control period: a chain of five history cells
// shifts, the newest entry takes a clamped setpoint and encoder adjustment,
// a weighted average forms the target and the output speed is ramp limited.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one period per transfer.
//   Output channel out_valid/out_ready/out_data carries one result for each
//   input transfer, in order. The result is registered: it appears in the
//   cycle after its input transfer. One transfer per cycle is sustained; the
//   only loops are the history and flag updates, done in the same cycle as
//   the transfer. While the receiver stalls, the result holds and in_ready
//   is low, so no period is taken until the waiting result is transferred.
//   cfg_we writes max_step from cfg_wdata at once; write it only when idle.
//   Reset clears the history to zero, both sticky flags, the output valid,
//   and sets max_step to 50.
// ----------------------------------------------------------------------------
module setpoint_smoother_ramp_limiter_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ssrl_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ssrl_pkg::out_t             out_data,
  input  logic                       cfg_we,
  input  logic [ssrl_pkg::VAL_W-1:0] cfg_wdata
);

  logic                       advance;
  logic [ssrl_pkg::VAL_W-1:0] max_step;
  logic [ssrl_pkg::VAL_W-1:0] newest;
  logic [ssrl_pkg::VAL_W-1:0] hist [ssrl_pkg::HIST_DEPTH];
  logic [ssrl_pkg::VAL_W-1:0] feed [ssrl_pkg::HIST_DEPTH];
  logic [ssrl_pkg::SUM_W-1:0] sums [ssrl_pkg::HIST_DEPTH+1];
  logic [ssrl_pkg::VAL_W-1:0] target;
  logic [ssrl_pkg::VAL_W-1:0] speed;
  ssrl_pkg::status_t          status;
  ssrl_pkg::out_t             out_data_next;

  assign in_ready = !out_valid || out_ready;
  assign advance = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_step <= ssrl_pkg::STEP_RESET;
    end else if (cfg_we) begin
      max_step <= cfg_wdata;
    end
  end

  ssrl_head u_head (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item       (in_data),
    .newest_old (hist[0]),
    .newest     (newest),
    .status     (status)
  );

  assign sums[0] = '0;

  for (genvar i = 0; i < ssrl_pkg::HIST_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign feed[i] = newest;
    end else begin : g_rest
      assign feed[i] = hist[i-1];
    end
    ssrl_cell #(
      .SHIFT (ssrl_pkg::WEIGHT_SHIFT[i])
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .value_in (feed[i]),
      .sum_in   (sums[i]),
      .value    (hist[i]),
      .sum_out  (sums[i+1])
    );
  end

  assign target = sums[ssrl_pkg::HIST_DEPTH][ssrl_pkg::AVG_SHIFT +: ssrl_pkg::VAL_W];

  ssrl_ramp u_ramp (
    .target        (target),
    .current_speed (in_data.current_speed),
    .max_step      (max_step),
    .new_speed     (speed)
  );

  always_comb begin
    out_data_next.new_speed = speed;
    out_data_next.target_average = target;
    out_data_next.conversion_failed = status.conversion_failed;
    out_data_next.missing_input = !in_data.has_value;
    out_data_next.encoder_used = status.encoder_used;
    out_data_next.clamped_high = status.clamped_high;
    out_data_next.clamped_low = status.clamped_low;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= out_data_next;
    end
  end

  a_accept_gives_result : assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("input transfer did not produce a result");

  a_history_shifts : assert property (@(posedge clk) disable iff (rst)
    advance |=> hist[1] == $past(hist[0]) && hist[4] == $past(hist[3]))
    else $error("history did not shift on transfer");

  a_flags_exclusive : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.clamped_high && out_data.clamped_low))
    else $error("both clamp flags set");

  a_status_exclusive : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.missing_input && out_data.conversion_failed))
    else $error("missing input and conversion failure together");

  a_history_holds : assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(hist[0]) && $stable(hist[4]))
    else $error("history changed without a transfer");

endmodule
